>>> hw/rtl/wpwa_pkg.sv
// Shared widths, codes and state types of the weighted point window average block.
`timescale 1ns / 1ps

package wpwa_pkg;

   localparam int SLOTS_DEFAULT = 20;

   localparam int OP_W       = 2;
   localparam int COORD_W    = 16;
   localparam int WEIGHT_W   = 24;
   localparam int COUNT_W    = 6;
   localparam int PROD_W     = COORD_W + WEIGHT_W + 1;
   localparam int MEAN_W     = 16;
   localparam int WORD_W     = WEIGHT_W + 2 * COORD_W;

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_FLOOR = 24'd7;

   typedef enum logic [OP_W-1:0] {
      OP_ADD       = 2'd0,
      OP_OVERWRITE = 2'd1,
      OP_AVERAGE   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV_X,
      ST_DIV_Y,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/wpwa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module wpwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/wpwa_divider.sv
// Sequential signed-by-unsigned restoring divider that yields a short quotient.
`timescale 1ns / 1ps

module wpwa_divider #(
   parameter int DIVIDEND_W = 46,
   parameter int DIVISOR_W  = 29
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [DIVIDEND_W-1:0]        dividend,
   input  logic [DIVISOR_W-1:0]                divisor,
   output logic                                done,
   output logic signed [wpwa_pkg::MEAN_W-1:0]  quotient
);

   localparam int QW   = wpwa_pkg::MEAN_W;
   localparam int PADW = DIVIDEND_W - DIVISOR_W - (QW - 1);
   localparam int CW   = $clog2(QW);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] sh_ff, sh_in;
   logic [QW-1:0]         quo_ff, quo_in;
   logic                  neg_ff, neg_in;
   logic [DIVIDEND_W-1:0] magnitude;
   logic                  fits;

   assign magnitude = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend)
                                             : DIVIDEND_W'(dividend);
   assign fits = rem_ff >= sh_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = magnitude;
         sh_in   = {{PADW{1'b0}}, divisor, {(QW - 1){1'b0}}};
         quo_in  = '0;
         neg_in  = dividend[DIVIDEND_W-1];
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - sh_ff;
         end
         quo_in = {quo_ff[QW-2:0], fits};
         sh_in  = sh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? $signed(-quo_ff) : $signed(quo_ff);

endmodule

>>> hw/rtl/weighted_point_window_average.sv
// Top level of the weighted point window average: slot ring, scan sequencer and output stage.
`timescale 1ns / 1ps

// The block keeps a ring of SLOTS weighted points in a RAM, with a valid flag
// per slot in flip-flops. Each request transfer on the req_ channel carries one
// operation in req_tuser: add (advance the slot pointer, then store), overwrite
// (store in the current slot) or average. Add and overwrite return nothing.
// An average walks back from the current slot, one slot per cycle, reading
// the valid slots from the RAM and accumulating weighted sums; the scan visits
// up to SLOTS slots, and then drains the read, multiply and accumulate stages.
// The two means then go one after the other through a shared divider. An
// average gives its response as one transfer on the rsp_ channel. Requests
// are taken one at a time; a new request is taken while the last response
// still waits in the output register, and a finished average holds until
// that register is free.
// Reset clears every valid flag and the slot pointer at once; the block takes
// requests in the first cycle after reset.
module weighted_point_window_average #(
   parameter int SLOTS = wpwa_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_x, point_y, weight, query_count, zero fill
   input  logic [wpwa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation, point_valid
   input  logic [wpwa_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // mean_x, mean_y
   output logic [wpwa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // mean_valid
   output logic [wpwa_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNTW   = $clog2(SLOTS + 1);
   localparam int ACCW   = wpwa_pkg::PROD_W + CNTW;
   localparam int WSUMW  = wpwa_pkg::WEIGHT_W + CNTW;
   localparam int CW     = wpwa_pkg::COORD_W;
   localparam int WW     = wpwa_pkg::WEIGHT_W;

   wpwa_pkg::op_type    req_op;
   logic                req_point_valid;
   logic [CW-1:0]       req_x;
   logic [CW-1:0]       req_y;
   logic [WW-1:0]       req_weight;
   logic [WW-1:0]       floored_weight;
   logic [wpwa_pkg::COUNT_W-1:0] req_count;

   wpwa_pkg::state_type state_ff, state_in;
   logic [SW-1:0]       write_slot_ff, write_slot_in;
   logic [SLOTS-1:0]    valid_ff;
   logic [SW:0]         slot_plus;
   logic [SW-1:0]       next_slot;
   logic [SW-1:0]       pos_ff, pos_in;
   logic [CNTW-1:0]     step_ff, step_in;
   logic [CNTW-1:0]     issued_ff, issued_in;
   logic [CNTW-1:0]     want_ff, want_in;
   logic                hit;

   logic                ram_we;
   logic [SW-1:0]       ram_waddr;
   logic                ram_re;
   logic [wpwa_pkg::WORD_W-1:0] ram_rdata;

   logic                acc_clear;
   logic                rd_vld_ff;
   logic                prod_vld_ff;
   logic signed [wpwa_pkg::PROD_W-1:0] prod_x_ff;
   logic signed [wpwa_pkg::PROD_W-1:0] prod_y_ff;
   logic [WW-1:0]       prod_w_ff;
   logic signed [CW-1:0] rd_x;
   logic signed [CW-1:0] rd_y;
   logic [WW-1:0]       rd_w;
   logic signed [ACCW-1:0] sx_ff;
   logic signed [ACCW-1:0] sy_ff;
   logic [WSUMW-1:0]    sw_ff;

   logic                div_start;
   logic                div_done;
   logic signed [ACCW-1:0] div_dividend;
   logic signed [wpwa_pkg::MEAN_W-1:0] div_quotient;
   logic                qx_load;
   logic                qy_load;
   logic signed [wpwa_pkg::MEAN_W-1:0] qx_ff;
   logic signed [wpwa_pkg::MEAN_W-1:0] qy_ff;

   logic                rsp_load;
   logic                rsp_valid_ff;
   logic                mean_valid_ff;
   logic [wpwa_pkg::MEAN_W-1:0] mean_x_ff;
   logic [wpwa_pkg::MEAN_W-1:0] mean_y_ff;

   assign req_op          = wpwa_pkg::op_type'(req_tuser[1:0]);
   assign req_point_valid = req_tuser[2];
   assign req_x           = req_tdata[15:0];
   assign req_y           = req_tdata[31:16];
   assign req_weight      = req_tdata[55:32];
   assign req_count       = req_tdata[61:56];
   assign floored_weight  = (req_weight < wpwa_pkg::WEIGHT_FLOOR) ? wpwa_pkg::WEIGHT_FLOOR
                                                                 : req_weight;

   assign slot_plus  = {1'b0, write_slot_ff} + 1'b1;
   assign next_slot  = (slot_plus >= (SW + 1)'(SLOTS)) ? '0 : slot_plus[SW-1:0];
   assign hit        = valid_ff[pos_ff];
   assign req_tready = (state_ff == wpwa_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      issued_in     = issued_ff;
      want_in       = want_ff;
      ram_we        = 1'b0;
      ram_waddr     = write_slot_ff;
      ram_re        = 1'b0;
      acc_clear     = 1'b0;
      div_start     = 1'b0;
      qx_load       = 1'b0;
      qy_load       = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         wpwa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_op)
                  wpwa_pkg::OP_ADD: begin
                     ram_we        = 1'b1;
                     ram_waddr     = next_slot;
                     write_slot_in = next_slot;
                  end
                  wpwa_pkg::OP_OVERWRITE: begin
                     ram_we = 1'b1;
                  end
                  wpwa_pkg::OP_AVERAGE: begin
                     if (req_count > wpwa_pkg::COUNT_W'(SLOTS)) begin
                        want_in = CNTW'(SLOTS);
                     end else if (req_count == '0) begin
                        want_in = CNTW'(1);
                     end else begin
                        want_in = req_count[CNTW-1:0];
                     end
                     pos_in    = write_slot_ff;
                     step_in   = '0;
                     issued_in = '0;
                     acc_clear = 1'b1;
                     state_in  = wpwa_pkg::ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         wpwa_pkg::ST_SCAN: begin
            ram_re    = hit;
            issued_in = issued_ff + CNTW'(hit);
            step_in   = step_ff + 1'b1;
            pos_in    = (pos_ff == '0) ? SW'(SLOTS - 1) : pos_ff - 1'b1;
            if ((step_ff == CNTW'(SLOTS - 1)) || (hit && (issued_ff + 1'b1 == want_ff))) begin
               state_in = wpwa_pkg::ST_DRAIN;
            end
         end
         wpwa_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               if (sw_ff == '0) begin
                  state_in = wpwa_pkg::ST_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = wpwa_pkg::ST_DIV_X;
               end
            end
         end
         wpwa_pkg::ST_DIV_X: begin
            if (div_done) begin
               qx_load   = 1'b1;
               div_start = 1'b1;
               state_in  = wpwa_pkg::ST_DIV_Y;
            end
         end
         wpwa_pkg::ST_DIV_Y: begin
            if (div_done) begin
               qy_load  = 1'b1;
               state_in = wpwa_pkg::ST_DONE;
            end
         end
         wpwa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = wpwa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wpwa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wpwa_pkg::ST_IDLE;
         write_slot_ff <= '0;
         valid_ff      <= '0;
         pos_ff        <= '0;
         step_ff       <= '0;
         issued_ff     <= '0;
         want_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         pos_ff        <= pos_in;
         step_ff       <= step_in;
         issued_ff     <= issued_in;
         want_ff       <= want_in;
         if (ram_we) begin
            valid_ff[ram_waddr] <= req_point_valid;
         end
      end
   end

   wpwa_ram #(
      .WIDTH (wpwa_pkg::WORD_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({floored_weight, req_y, req_x}),
      .rd_en   (ram_re),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   assign rd_x = ram_rdata[CW-1:0];
   assign rd_y = ram_rdata[2*CW-1:CW];
   assign rd_w = ram_rdata[wpwa_pkg::WORD_W-1:2*CW];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= ram_re;
         prod_vld_ff <= rd_vld_ff;
      end
      prod_x_ff <= wpwa_pkg::PROD_W'(rd_x) * wpwa_pkg::PROD_W'($signed({1'b0, rd_w}));
      prod_y_ff <= wpwa_pkg::PROD_W'(rd_y) * wpwa_pkg::PROD_W'($signed({1'b0, rd_w}));
      prod_w_ff <= rd_w;
      if (acc_clear) begin
         sx_ff <= '0;
         sy_ff <= '0;
         sw_ff <= '0;
      end else if (prod_vld_ff) begin
         sx_ff <= sx_ff + {{CNTW{prod_x_ff[wpwa_pkg::PROD_W-1]}}, prod_x_ff};
         sy_ff <= sy_ff + {{CNTW{prod_y_ff[wpwa_pkg::PROD_W-1]}}, prod_y_ff};
         sw_ff <= sw_ff + {{CNTW{1'b0}}, prod_w_ff};
      end
   end

   assign div_dividend = (state_ff == wpwa_pkg::ST_DIV_X) ? sy_ff : sx_ff;

   wpwa_divider #(
      .DIVIDEND_W (ACCW),
      .DIVISOR_W  (WSUMW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (sw_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (qx_load) begin
         qx_ff <= div_quotient;
      end
      if (qy_load) begin
         qy_ff <= div_quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         mean_valid_ff <= (sw_ff != '0);
         mean_x_ff     <= (sw_ff != '0) ? qx_ff : '0;
         mean_y_ff     <= (sw_ff != '0) ? qy_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {mean_y_ff, mean_x_ff};
   assign rsp_tuser  = mean_valid_ff;

endmodule
